>>> rtl/core/calibrated_sample_window_averager_core_defines.svh
// Assertion macros for the sample window averager
`ifndef CALIBRATED_SAMPLE_WINDOW_AVERAGER_CORE_DEFINES_SVH
`define CALIBRATED_SAMPLE_WINDOW_AVERAGER_CORE_DEFINES_SVH
`define CSWA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CSWA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/core/cswa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswa_pkg
// Shared types and constants of the sample window averager.
// ----------------------------------------------------------------------------
package cswa_pkg;
  localparam int RingDepthDef = 64;
  localparam int NumCfg = 7;
  localparam logic [2:0] CfgPhLow = 3'd0;
  localparam logic [2:0] CfgPhMid = 3'd1;
  localparam logic [2:0] CfgPhHigh = 3'd2;
  localparam logic [2:0] CfgEcLow = 3'd3;
  localparam logic [2:0] CfgEcHigh = 3'd4;
  localparam logic [2:0] CfgInterval = 3'd5;
  localparam logic [2:0] CfgWindow = 3'd6;
  localparam logic signed [12:0] TempDefault = 13'sd352;
  localparam logic signed [12:0] TempLowLim = -13'sd1600;
  localparam logic signed [12:0] TempHighLim = 13'sd2400;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL_PH, ST_DIV_PH, ST_CAL_EC, ST_DIV_EC, ST_STORE,
    ST_SCAN, ST_MEAN_PH, ST_MEAN_EC, ST_MEAN_T, ST_OUT
  } state_e;
endpackage

>>> rtl/core/calibrated_sample_window_averager_core.sv
`timescale 1ns / 1ps
// A tick that stores a sample runs the 48-step shared divider up to twice, and a
// query up to three times (for the pH, EC and temperature means) after the
// one-entry-per-cycle ring scan. One item at a time.
// Reset (rst_ni low, asynchronous) restores the calibration registers, empties
// the ring and clears the last sample time; ring RAM contents are not cleared.
// ----------------------------------------------------------------------------
// calibrated_sample_window_averager_core
// Calibrates pH/EC samples, stores them in a ring and averages a time window.
// ----------------------------------------------------------------------------
module calibrated_sample_window_averager_core import cswa_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // now_ms[31:0], ph_code[43:32], ec_code[55:44], temp_reading[68:56], pad
  input  logic [71:0]   s_axis_tdata,
  // mode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // report_time[31:0], mean_ph[47:32], mean_ec[63:48], mean_temp[76:64],
  // used_count[83:77], pad
  output logic [87:0]   m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [27:0]   cfg_data_i
);
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int EW = 32 + 16 + 16 + 13;

  state_e state_q, state_d;
  logic [27:0] cfg_q [5];
  logic [15:0] intv_q;
  logic [23:0] win_q;
  logic        mode_q;
  logic [31:0] now_q, last_q;
  logic [11:0] phc_q, ecc_q;
  logic signed [12:0] temp_q;
  logic [CW-1:0] fill_q, cnt_q;
  logic [AW-1:0] slot_q, idx_q;
  logic [CW-1:0] scan_q;
  logic          rd_vld_q;
  logic signed [15:0] ph_q, ec_q;
  logic signed [25:0] sp_q, se_q;
  logic signed [22:0] st_q;
  logic signed [15:0] mph_q, mec_q;
  logic signed [12:0] mt_q;
  logic        out_vld_q;
  logic [87:0] out_q;

  // calibration segment operands
  logic [27:0] pa, pb;
  logic [11:0] code;
  logic signed [13:0] dr, dra;
  logic signed [16:0] dv, dva;
  logic signed [12:0] dc;
  logic signed [31:0] prod_q;
  logic signed [15:0] va_q;
  logic        flat_q;
  logic [15:0] dabs_q;
  logic signed [47:0] dnum;
  logic [15:0] dden;
  logic        dstart, ddone;
  logic signed [47:0] dquo;
  logic signed [47:0] sum_v;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_vld_q;
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 28'd0;
      cfg_q[1] <= 28'd134219520;
      cfg_q[2] <= 28'd268373504;
      cfg_q[3] <= 28'd0;
      cfg_q[4] <= 28'd268371200;
      intv_q <= 16'd250;
      win_q <= 24'd10000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPhLow, CfgPhMid, CfgPhHigh, CfgEcLow, CfgEcHigh:
          cfg_q[cfg_index_i] <= cfg_data_i;
        CfgInterval: intv_q <= cfg_data_i[15:0];
        CfgWindow: win_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // segment select
  always_comb begin
    if (state_q == ST_CAL_PH) begin
      code = phc_q;
      if (phc_q <= cfg_q[CfgPhMid][27:16]) begin
        pa = cfg_q[CfgPhLow];
        pb = cfg_q[CfgPhMid];
      end else begin
        pa = cfg_q[CfgPhMid];
        pb = cfg_q[CfgPhHigh];
      end
    end else begin
      code = ecc_q;
      pa = cfg_q[CfgEcLow];
      pb = cfg_q[CfgEcHigh];
    end
    dr = $signed({2'b0, pb[27:16]}) - $signed({2'b0, pa[27:16]});
    dv = $signed({pb[15], pb[15:0]}) - $signed({pa[15], pa[15:0]});
    dra = dr[13] ? -dr : dr;
    dva = dr[13] ? -dv : dv;
    dc = $signed({1'b0, code}) - $signed({1'b0, pa[27:16]});
  end

  always_comb begin
    dstart = 1'b0;
    dnum = '0;
    dden = 16'd1;
    sum_v = '0;
    unique case (state_q)
      ST_DIV_PH, ST_DIV_EC: begin
        dstart = !flat_q;
        dnum = 48'(prod_q);
        dden = dabs_q;
      end
      ST_MEAN_PH: sum_v = 48'(sp_q);
      ST_MEAN_EC: sum_v = 48'(se_q);
      ST_MEAN_T: sum_v = 48'(st_q);
      default: ;
    endcase
    if (state_q == ST_MEAN_PH || state_q == ST_MEAN_EC || state_q == ST_MEAN_T) begin
      dstart = (cnt_q != '0);
      dnum = sum_v;
      dden = 16'(cnt_q);
    end
  end

  logic dbusy_q;
  cswa_div u_div (
    .clk_i, .rst_ni, .start_i(dstart && !dbusy_q), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [47:0] cal_v;
  assign cal_v = 48'(va_q) + dquo;

  // ring RAM
  logic         we;
  logic [EW-1:0] wdata, rdata;
  logic signed [12:0] temp_fix;
  assign temp_fix = (temp_q <= TempLowLim || temp_q >= TempHighLim) ? TempDefault : temp_q;
  assign we = (state_q == ST_STORE);
  assign wdata = {temp_fix, ec_q, ph_q, now_q};
  cswa_ram #(.Width(EW), .Depth(RING_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(slot_q), .wdata_i(wdata),
    .raddr_i(idx_q), .rdata_o(rdata)
  );

  logic [31:0] age;
  assign age = now_q - rdata[31:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) begin
          if ((s_axis_tdata[31:0] - last_q) >= {16'd0, intv_q}) state_d = ST_CAL_PH;
          else if (s_axis_tuser) state_d = ST_SCAN;
        end
      ST_CAL_PH: state_d = ST_DIV_PH;
      ST_DIV_PH: if (flat_q || ddone) state_d = ST_CAL_EC;
      ST_CAL_EC: state_d = ST_DIV_EC;
      ST_DIV_EC: if (flat_q || ddone) state_d = ST_STORE;
      ST_STORE: state_d = mode_q ? ST_SCAN : ST_IDLE;
      ST_SCAN: if (scan_q == fill_q && !rd_vld_q) state_d = ST_MEAN_PH;
      ST_MEAN_PH: if (cnt_q == '0 || ddone) state_d = ST_MEAN_EC;
      ST_MEAN_EC: if (cnt_q == '0 || ddone) state_d = ST_MEAN_T;
      ST_MEAN_T: if (cnt_q == '0 || ddone) state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      slot_q <= '0;
      last_q <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
      dbusy_q <= 1'b0;
      scan_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (ddone) dbusy_q <= 1'b0;
      else if (dstart) dbusy_q <= 1'b1;
      if (state_q != state_d) dbusy_q <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
      if (state_q == ST_OUT) out_vld_q <= 1'b1;
      if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready
          && (s_axis_tdata[31:0] - last_q) >= {16'd0, intv_q})
        last_q <= s_axis_tdata[31:0];
      if (we) begin
        slot_q <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + AW'(1);
        if (fill_q != CW'(RING_DEPTH)) fill_q <= fill_q + CW'(1);
      end
      if (state_d == ST_SCAN && state_q != ST_SCAN) begin
        scan_q <= '0;
        idx_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rd_vld_q <= (scan_q != fill_q);
        if (scan_q != fill_q) begin
          scan_q <= scan_q + CW'(1);
          idx_q <= idx_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      mode_q <= s_axis_tuser;
      now_q <= s_axis_tdata[31:0];
      phc_q <= s_axis_tdata[43:32];
      ecc_q <= s_axis_tdata[55:44];
      temp_q <= s_axis_tdata[68:56];
      sp_q <= '0;
      se_q <= '0;
      st_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == ST_CAL_PH || state_q == ST_CAL_EC) begin
      prod_q <= 32'(dva) * 32'(dc);
      va_q <= pa[15:0];
      flat_q <= (dr == 14'sd0);
      dabs_q <= 16'(dra);
    end
    if (state_q == ST_DIV_PH) ph_q <= flat_q ? va_q : sat16(cal_v);
    if (state_q == ST_DIV_EC) ec_q <= flat_q ? va_q : sat16(cal_v);
    if (state_q == ST_SCAN && rd_vld_q && age <= {8'd0, win_q}) begin
      sp_q <= sp_q + 26'($signed(rdata[47:32]));
      se_q <= se_q + 26'($signed(rdata[63:48]));
      st_q <= st_q + 23'($signed(rdata[76:64]));
      cnt_q <= cnt_q + CW'(1);
    end
    if (ddone) begin
      if (state_q == ST_MEAN_PH) mph_q <= dquo[15:0];
      if (state_q == ST_MEAN_EC) mec_q <= dquo[15:0];
      if (state_q == ST_MEAN_T) mt_q <= dquo[12:0];
    end
    if (state_q == ST_MEAN_PH && cnt_q == '0) begin
      mph_q <= '0;
      mec_q <= '0;
      mt_q <= '0;
    end
    if (state_q == ST_OUT)
      out_q <= {4'd0, 7'(cnt_q), mt_q, mec_q, mph_q, now_q};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_q;
endmodule

>>> rtl/core/cswa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswa_ram
// Single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module cswa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/cswa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswa_div
// Sequential signed divider, round to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module cswa_div import cswa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic [15:0]        den_i,
  output logic               done_o,
  output logic signed [47:0] quo_o
);
  logic [47:0] rem_q, rem_d, mag_q, mag_d, quo_q, quo_d;
  logic [15:0] den_q;
  logic        neg_q, busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] trial;
  logic [47:0] absn, shifted;
  logic [47:0] rq;

  assign absn = num_i[47] ? (48'd0 - num_i) : num_i;
  assign shifted = {rem_q[46:0], mag_q[47]};
  assign trial = {1'b0, shifted} - {33'd0, den_q};

  always_comb begin
    rem_d = rem_q;
    mag_d = mag_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      mag_d = {mag_q[46:0], 1'b0};
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= busy_q && (cnt_q == 6'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd47;
      end else begin
        busy_q <= busy_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // bias by half the divisor, then truncate
      mag_q <= absn + {33'd0, den_i[15:1]};
      rem_q <= '0;
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[47];
    end else begin
      mag_q <= mag_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rq = neg_q ? (48'd0 - quo_q) : quo_q;
  assign quo_o = rq;
endmodule

>>> rtl/core/cswa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswa_checker
// Port-level checks of the sample window averager.
// ----------------------------------------------------------------------------
`include "calibrated_sample_window_averager_core_defines.svh"
module cswa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  `CSWA_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "result dropped")
  `CSWA_ASSERT(a_no_take_pending, clk_i, rst_ni,
    m_axis_tvalid |-> !s_axis_tready, "input taken while result pending")
  `CSWA_ASSERT(a_count_range, clk_i, rst_ni,
    m_axis_tvalid |-> m_axis_tdata[83:77] <= 7'd64, "count too large")
  `CSWA_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result in reset")
endmodule

bind calibrated_sample_window_averager_core cswa_checker u_cswa_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

>>> tb/tb_calibrated_sample_window_averager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calibrated_sample_window_averager_core
// Self-checking bench: directed rows, then random ticks and queries, compared
// against a behavioral predictor of calibration, ring storage and window mean.
// ----------------------------------------------------------------------------
module tb_calibrated_sample_window_averager_core import cswa_pkg::*;;

  localparam int Depth = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [27:0] cfg_data_i = '0;

  calibrated_sample_window_averager_core dut (.*);

  typedef struct packed {
    logic [6:0]         cnt;
    logic signed [12:0] temp;
    logic signed [15:0] ec;
    logic signed [15:0] ph;
    logic [31:0]        when;
  } report_t;

  typedef struct {
    logic               query;
    logic [31:0]        now;
    logic [11:0]        phc;
    logic [11:0]        ecc;
    logic signed [12:0] temp;
    logic               fixed;
    report_t            rep;
  } row_t;

  logic [27:0] cal_regs [NumCfg];
  logic [31:0] ring_time [Depth];
  int          ring_ph [Depth];
  int          ring_ec [Depth];
  int          ring_temp [Depth];
  int          ring_fill;
  int          ring_slot;
  logic [31:0] last_stored;

  report_t     pending_reports[$];
  int          errors = 0;
  int          mismatches = 0;
  int          reports_seen = 0;
  int          items_sent = 0;
  bit          drain_busy = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int seg_value(logic [27:0] a, logic [27:0] b, longint code);
    longint ca, cb, va, vb, dr, dv;
    ca = a[27:16];
    cb = b[27:16];
    va = longint'($signed(a[15:0]));
    vb = longint'($signed(b[15:0]));
    dr = cb - ca;
    dv = vb - va;
    if (dr == 0) return clamp16(va);
    if (dr < 0) begin
      dr = -dr;
      dv = -dv;
    end
    return clamp16(va + round_div(dv * (code - ca), dr));
  endfunction

  function automatic void predictor_reset();
    cal_regs[CfgPhLow] = 28'd0;
    cal_regs[CfgPhMid] = 28'd134219520;
    cal_regs[CfgPhHigh] = 28'd268373504;
    cal_regs[CfgEcLow] = 28'd0;
    cal_regs[CfgEcHigh] = 28'd268371200;
    cal_regs[CfgInterval] = 28'd250;
    cal_regs[CfgWindow] = 28'd10000;
    ring_fill = 0;
    ring_slot = 0;
    last_stored = '0;
  endfunction

  function automatic void w_init();
    for (int i = 0; i < Depth; i++) begin
      ring_time[i] = '0;
      ring_ph[i] = 0;
      ring_ec[i] = 0;
      ring_temp[i] = 0;
    end
  endfunction

  function automatic void predict_sample(row_t r);
    int t;
    longint sp, se, st;
    int n;
    report_t rep;
    t = r.temp;
    if (32'(r.now - last_stored) >= 32'(cal_regs[CfgInterval][15:0])) begin
      last_stored = r.now;
      if (r.phc <= cal_regs[CfgPhMid][27:16])
        ring_ph[ring_slot] = seg_value(cal_regs[CfgPhLow], cal_regs[CfgPhMid], r.phc);
      else
        ring_ph[ring_slot] = seg_value(cal_regs[CfgPhMid], cal_regs[CfgPhHigh], r.phc);
      ring_ec[ring_slot] = seg_value(cal_regs[CfgEcLow], cal_regs[CfgEcHigh], r.ecc);
      if (t <= -1600 || t >= 2400) t = 352;
      ring_temp[ring_slot] = t;
      ring_time[ring_slot] = r.now;
      ring_slot = (ring_slot + 1) % Depth;
      if (ring_fill < Depth) ring_fill++;
    end
    if (!r.query) return;
    sp = 0;
    se = 0;
    st = 0;
    n = 0;
    for (int i = 0; i < ring_fill; i++) begin
      if (32'(r.now - ring_time[i]) <= 32'(cal_regs[CfgWindow][23:0])) begin
        sp += ring_ph[i];
        se += ring_ec[i];
        st += ring_temp[i];
        n++;
      end
    end
    rep = '0;
    rep.when = r.now;
    rep.cnt = 7'(n);
    if (n != 0) begin
      rep.ph = 16'(round_div(sp, n));
      rep.ec = 16'(round_div(se, n));
      rep.temp = 13'(round_div(st, n));
    end
    if (r.fixed && rep != r.rep) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: table %h predictor %h", r.rep, rep);
    end
    pending_reports.push_back(rep);
  endfunction

  task automatic send_item(row_t r);
    int idle;
    idle = $urandom_range(0, 15);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.query;
    s_axis_tdata <= {3'b0, r.temp, r.ecc, r.phc, r.now};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(r);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [27:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgInterval) cal_regs[idx] = {12'b0, val[15:0]};
    else if (idx == CfgWindow) cal_regs[idx] = {4'b0, val[23:0]};
    else cal_regs[idx] = val;
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      report_t got, want;
      got = m_axis_tdata[83:0];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("unexpected report transaction %h", got);
      end else begin
        want = pending_reports.pop_front();
        if (got != want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display({"report mismatch: exp t=%h ph=%0d ec=%0d tp=%0d n=%0d",
                      " got t=%h ph=%0d ec=%0d tp=%0d n=%0d"},
                     want.when, want.ph, want.ec, want.temp, want.cnt,
                     got.when, got.ph, got.ec, got.temp, got.cnt);
        end
      end
    end
  end

  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (w > 0) begin
        w--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) w = ($urandom_range(0, 3) == 0) ? 0 :
                                                 $urandom_range(0, 15);
      end
    end
  end

  function automatic row_t mk(logic q, logic [31:0] t, logic [11:0] p, logic [11:0] e,
                              logic signed [12:0] tp);
    row_t r;
    r.query = q;
    r.now = t;
    r.phc = p;
    r.ecc = e;
    r.temp = tp;
    r.fixed = 1'b0;
    r.rep = '0;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, report_t rep);
    r.fixed = 1'b1;
    r.rep = rep;
    return r;
  endfunction

  function automatic row_t rand_row(logic [31:0] t, int qpct);
    logic signed [12:0] tp;
    tp = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3998) - 1599);
    return mk($urandom_range(0, 99) < qpct, t, 12'($urandom), 12'($urandom), tp);
  endfunction

  row_t        table_rows[$];
  logic [31:0] clock_ms;
  int          setting;

  initial begin
    predictor_reset();
    w_init();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty query before any interval has passed, then calibrated extremes
    table_rows.push_back(mkx(mk(1, 32'd0, 12'd0, 12'd0, 13'sd0), '{7'd0, 13'sd0, 16'sd0,
                                                                   16'sd0, 32'd0}));
    table_rows.push_back(mkx(mk(1, 32'd250, 12'd0, 12'd0, 13'sd400),
                             '{7'd1, 13'sd400, 16'sd0, 16'sd0, 32'd250}));
    table_rows.push_back(mkx(mk(1, 32'd500, 12'd4095, 12'd4095, -13'sd1600),
                             '{7'd2, 13'sd376, 16'sd640, 16'sd1792, 32'd500}));
    table_rows.push_back(mk(1, 32'd750, 12'd2048, 12'd2048, 13'sd2400));
    table_rows.push_back(mk(0, 32'd800, 12'd1, 12'd1, 13'sd2399));
    table_rows.push_back(mk(1, 32'd1000, 12'd2049, 12'd4094, -13'sd1599));
    table_rows.push_back(mk(0, 32'd1250, 12'hfff, 12'h000, 13'h0fff));
    table_rows.push_back(mk(0, 32'd1500, 12'h000, 12'hfff, 13'h1000));
    table_rows.push_back(mk(1, 32'hffff_ffff, 12'h555, 12'haaa, 13'h1555));
    table_rows.push_back(mk(1, 32'd100, 12'haaa, 12'h555, 13'h0aaa));
    table_rows.push_back(mk(1, 32'd200000, 12'd7, 12'd9, 13'sd0));
    foreach (table_rows[i]) send_item(table_rows[i]);
    drain();

    clock_ms = 32'd300000;
    for (setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin
          write_reg(CfgPhLow, {12'd100, 16'h8000});
          write_reg(CfgPhMid, {12'd100, 16'h7fff});
          write_reg(CfgPhHigh, {12'd4000, 16'h8000});
          write_reg(CfgEcLow, {12'd4095, 16'h7fff});
          write_reg(CfgEcHigh, {12'd0, 16'h8000});
          write_reg(CfgInterval, 28'd1);
          write_reg(CfgWindow, 28'd0);
        end
        1: begin
          write_reg(CfgPhLow, 28'hfff_ffff);
          write_reg(CfgPhMid, 28'h000_0000);
          write_reg(CfgPhHigh, 28'hfff_ffff);
          write_reg(CfgEcLow, {12'd50, 16'd1000});
          write_reg(CfgEcHigh, {12'd50, 16'd2000});
          write_reg(CfgInterval, 28'd65535);
          write_reg(CfgWindow, 28'hff_ffff);
        end
        default: begin
          write_reg(CfgPhLow, 28'($urandom));
          write_reg(CfgPhMid, 28'($urandom));
          write_reg(CfgPhHigh, 28'($urandom));
          write_reg(CfgEcLow, 28'($urandom));
          write_reg(CfgEcHigh, 28'($urandom));
          write_reg(CfgInterval, 28'($urandom_range(1, 400)));
          write_reg(CfgWindow, 28'($urandom_range(0, 20000)));
        end
      endcase
      cfg_valid_i <= 1'b0;
      for (int k = 0; k < 280; k++) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 2 * cal_regs[CfgInterval] + 2);
        if (setting == 1 && k % 4 == 0) clock_ms += 32'd65535;
        send_item(rand_row(clock_ms, 35));
        if (k == 140) drain();
      end
      drain();
    end

    $display("sent %0d items over %0d register settings, %0d reports checked",
             items_sent, setting + 1, reports_seen);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cswa_pkg.sv
rtl/core/cswa_ram.sv
rtl/core/cswa_div.sv
rtl/core/calibrated_sample_window_averager_core.sv
rtl/core/cswa_checker.sv
tb/tb_calibrated_sample_window_averager_core.sv
